>>> rtl/core/atl_pkg.sv
`timescale 1ns / 1ps
// atl_pkg: shared types, widths, mode codes and the arctangent step table
// for the accelerometer tilt pipeline. Used by every file under rtl/core.
// No dependencies.
package atl_pkg;

  // default field widths
  localparam int ATL_SAMPLE_BITS     = 16;
  localparam int ATL_ANGLE_FRAC_BITS = 7;

  // samples are left-aligned into a 32-bit word for the rotation operands
  localparam int ATL_SCALED_W = 32;
  // rotation operands: scaled sample, its negation, or the 32-bit magnitude
  localparam int ATL_OP_W     = 33;
  // radicand and square root working registers
  localparam int ATL_RAD_W    = 64;
  localparam int ATL_SQRT_STEPS = 32;

  // rotation datapath
  localparam int ATL_CORDIC_ITERS = 60;
  localparam int ATL_PRE_SHIFT    = 23;
  localparam int ATL_CW           = 58;
  localparam int ATL_ACC_W        = 64;

  // angle to output unit conversion
  localparam int ATL_ANGLE_LSB  = 28;
  localparam int ATL_Q_W        = 34;
  localparam int ATL_DEG_SCALE  = 573;
  localparam int ATL_SCALE_W    = 11;
  localparam int ATL_DIV_SHIFT  = 32;
  localparam int ATL_ROUND_HALF = 5;
  localparam int ATL_RADIX      = 10;
  localparam int ATL_RECIP_W    = 29;
  localparam logic [ATL_RECIP_W-1:0] ATL_RECIP_TEN =
    ATL_RECIP_W'(64'd4294967296 / 64'd10);

  // front stages (square, radicand) + prerotation + four conversion stages
  localparam int ATL_LATENCY = ATL_SQRT_STEPS + ATL_CORDIC_ITERS + 7;

  // mode codes
  localparam logic [1:0] ATL_MODE_PITCH = 2'd0;
  localparam logic [1:0] ATL_MODE_ROLL  = 2'd1;
  localparam logic [1:0] ATL_MODE_YAW   = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [1:0] mode;
  } atl_meta_t;

  // word travelling down the square root chain
  typedef struct packed {
    atl_meta_t                      meta;
    logic signed [ATL_OP_W-1:0]     y_op;
    logic signed [ATL_SCALED_W-1:0] z_op;
    logic [ATL_RAD_W-1:0]           rem;
    logic [ATL_RAD_W-1:0]           root;
  } atl_sqrt_t;

  // word travelling down the rotation chain
  typedef struct packed {
    atl_meta_t                   meta;
    logic                        zero;
    logic signed [ATL_CW-1:0]    x;
    logic signed [ATL_CW-1:0]    y;
    logic signed [ATL_ACC_W-1:0] acc;
  } atl_cordic_t;

  // atan(2^-i) in Q60 radians by the alternating series, i >= 1
  function automatic logic [63:0] atl_atan_pow2(input int i);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    p   = 64'd1 << (60 - i);
    sum = '0;
    for (int k = 0; k < 40; k++) begin
      term = p / 64'(2 * k + 1);
      if (k[0]) sum = sum - term;
      else sum = sum + term;
      p = p >> (2 * i);
    end
    return sum;
  endfunction

  // atan(1/3) in Q60 radians by the same series
  function automatic logic [63:0] atl_atan_third();
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    p   = (64'd1 << 60) / 64'd3;
    sum = '0;
    for (int k = 0; k < 40; k++) begin
      term = p / 64'(2 * k + 1);
      if (k[0]) sum = sum - term;
      else sum = sum + term;
      p = p / 64'd3 / 64'd3;
    end
    return sum;
  endfunction

  // step angle of rotation i; step zero is atan(1/2) + atan(1/3)
  function automatic logic [63:0] atl_atan_tab(input int i);
    logic [63:0] t;
    if (i == 0) t = atl_atan_pow2(1) + atl_atan_third();
    else t = atl_atan_pow2(i);
    return t;
  endfunction

endpackage

>>> rtl/core/accel_tilt_angle.sv
`timescale 1ns / 1ps
// accel_tilt_angle: tilt angle from one accelerometer sample triple.
// Depends on atl_pkg, atl_sqrt_cell, atl_cordic_cell and atl_convert.
//
// One word is taken in every clock cycle (start high, busy low; busy is high
// only while rst_n is low) and its result appears, after every pipeline stage,
// as a one-cycle out_valid strobe, in accept order. The receiver cannot
// stall the block: each result is on out_angle_out for exactly that cycle and
// must be captured then. The pipeline is made of the cell chains: two front
// stages (squares, radicand), 32 square root cells, one prerotation stage,
// 60 rotation cells and four conversion stages. Mode 0 gives minus the sensor
// roll, mode 1 minus twice the sensor pitch, modes 2 and 3 give zero; the
// result is in units of 2^-ANGLE_FRAC_BITS degree, rounded to nearest.
module accel_tilt_angle #(
  parameter int SAMPLE_BITS     = atl_pkg::ATL_SAMPLE_BITS,
  parameter int ANGLE_FRAC_BITS = atl_pkg::ATL_ANGLE_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [SAMPLE_BITS-1:0]     in_x_sample,
  input  logic signed [SAMPLE_BITS-1:0]     in_y_sample,
  input  logic signed [SAMPLE_BITS-1:0]     in_z_sample,
  input  logic [1:0]                        in_mode,
  output logic                              out_valid,
  output logic signed [ANGLE_FRAC_BITS+8:0] out_angle_out
);
  import atl_pkg::*;

  localparam int GUARD = ATL_SCALED_W - SAMPLE_BITS;
  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam logic signed [ATL_ACC_W-1:0] QUARTER = $signed(atl_atan_tab(0) << 1);

  logic accept;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // stage A: left-align samples, squares, rotation y operand
  logic signed [ATL_SCALED_W-1:0] x_scaled;
  logic signed [ATL_SCALED_W-1:0] y_scaled;
  logic signed [ATL_SCALED_W-1:0] z_scaled;
  logic signed [SQ_W-1:0]         yy_s;
  logic signed [SQ_W-1:0]         zz_s;
  logic signed [ATL_OP_W-1:0]     yop_nxt;
  logic                           a_vld_r;
  logic [1:0]                     a_mode_r;
  logic [SQ_W-1:0]                a_yy_r;
  logic [SQ_W-1:0]                a_zz_r;
  logic signed [ATL_OP_W-1:0]     a_yop_r;
  logic signed [ATL_SCALED_W-1:0] a_zop_r;

  always_comb begin
    x_scaled = ATL_SCALED_W'(in_x_sample) <<< GUARD;
    y_scaled = ATL_SCALED_W'(in_y_sample) <<< GUARD;
    z_scaled = ATL_SCALED_W'(in_z_sample) <<< GUARD;
    yy_s     = SQ_W'(in_y_sample) * SQ_W'(in_y_sample);
    zz_s     = SQ_W'(in_z_sample) * SQ_W'(in_z_sample);
    // roll vectors (r, -x); pitch vectors (z, y)
    if (in_mode == ATL_MODE_ROLL) yop_nxt = -ATL_OP_W'(x_scaled);
    else yop_nxt = ATL_OP_W'(y_scaled);
  end

  always_ff @(posedge clk) begin
    a_mode_r <= in_mode;
    a_yy_r   <= $unsigned(yy_s);
    a_zz_r   <= $unsigned(zz_s);
    a_yop_r  <= yop_nxt;
    a_zop_r  <= z_scaled;
  end

  // stage B: radicand (y^2 + z^2) scaled to the 32-bit frame
  logic [ATL_RAD_W-1:0]           rad_nxt;
  logic                           b_vld_r;
  logic [1:0]                     b_mode_r;
  logic [ATL_RAD_W-1:0]           b_rad_r;
  logic signed [ATL_OP_W-1:0]     b_yop_r;
  logic signed [ATL_SCALED_W-1:0] b_zop_r;

  always_comb begin
    rad_nxt = (ATL_RAD_W'(a_yy_r) + ATL_RAD_W'(a_zz_r)) << (2 * GUARD);
  end

  always_ff @(posedge clk) begin
    b_mode_r <= a_mode_r;
    b_rad_r  <= rad_nxt;
    b_yop_r  <= a_yop_r;
    b_zop_r  <= a_zop_r;
  end

  // square root chain
  atl_sqrt_t sq_chain [0:ATL_SQRT_STEPS];

  always_comb begin
    sq_chain[0].meta.valid = b_vld_r;
    sq_chain[0].meta.mode  = b_mode_r;
    sq_chain[0].y_op       = b_yop_r;
    sq_chain[0].z_op       = b_zop_r;
    sq_chain[0].rem        = b_rad_r;
    sq_chain[0].root       = '0;
  end

  for (genvar j = 0; j < ATL_SQRT_STEPS; j++) begin : g_sqrt
    atl_sqrt_cell #(.STEP(j)) u_sqrt_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (sq_chain[j]),
      .d_out (sq_chain[j+1])
    );
  end

  // prerotation: pick operands, fold the left half plane by a quarter turn
  atl_sqrt_t                  tail;
  logic signed [ATL_OP_W-1:0] op_x;
  logic signed [ATL_CW-1:0]   xs;
  logic signed [ATL_CW-1:0]   ys;
  atl_cordic_t                pr_nxt;
  atl_cordic_t                pr_r;
  logic                       pr_vld_r;

  always_comb begin
    tail = sq_chain[ATL_SQRT_STEPS];
    if (tail.meta.mode == ATL_MODE_ROLL)
      op_x = $signed({1'b0, tail.root[ATL_SCALED_W-1:0]});
    else
      op_x = ATL_OP_W'(tail.z_op);
    xs = ATL_CW'(op_x) <<< ATL_PRE_SHIFT;
    ys = ATL_CW'(tail.y_op) <<< ATL_PRE_SHIFT;

    pr_nxt.meta = tail.meta;
    pr_nxt.zero = (op_x == '0) && (tail.y_op == '0);
    pr_nxt.x    = xs;
    pr_nxt.y    = ys;
    pr_nxt.acc  = '0;
    if (xs[ATL_CW-1]) begin
      if (!ys[ATL_CW-1]) begin
        pr_nxt.x   = ys;
        pr_nxt.y   = -xs;
        pr_nxt.acc = QUARTER;
      end else begin
        pr_nxt.x   = -ys;
        pr_nxt.y   = xs;
        pr_nxt.acc = -QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    pr_r <= pr_nxt;
  end

  // rotation chain
  atl_cordic_t rot_chain [0:ATL_CORDIC_ITERS];

  always_comb begin
    rot_chain[0]            = pr_r;
    rot_chain[0].meta.valid = pr_vld_r;
  end

  for (genvar i = 0; i < ATL_CORDIC_ITERS; i++) begin : g_rot
    atl_cordic_cell #(.ITER(i)) u_cordic_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (rot_chain[i]),
      .d_out (rot_chain[i+1])
    );
  end

  // output units and result register
  atl_convert #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_convert (
    .clk       (clk),
    .rst_n     (rst_n),
    .d_in      (rot_chain[ATL_CORDIC_ITERS]),
    .res_valid (out_valid),
    .res_angle (out_angle_out)
  );

  // front valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r  <= 1'b0;
      b_vld_r  <= 1'b0;
      pr_vld_r <= 1'b0;
    end else begin
      a_vld_r  <= accept;
      b_vld_r  <= a_vld_r;
      pr_vld_r <= tail.meta.valid;
    end
  end

endmodule

>>> rtl/core/atl_sqrt_cell.sv
`timescale 1ns / 1ps
// atl_sqrt_cell: one digit of the restoring integer square root, registered.
// Depends on atl_pkg.
module atl_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  atl_pkg::atl_sqrt_t d_in,
  output atl_pkg::atl_sqrt_t d_out
);
  import atl_pkg::*;

  localparam logic [ATL_RAD_W-1:0] BIT_VAL =
    {{(ATL_RAD_W-1){1'b0}}, 1'b1} << (ATL_RAD_W - 2 - 2 * STEP);

  logic [ATL_RAD_W-1:0] trial;
  atl_sqrt_t            stage_nxt;
  atl_sqrt_t            stage_r;
  logic                 vld_r;

  // subtract the trial value when it fits and set this root digit
  always_comb begin
    trial     = d_in.root + BIT_VAL;
    stage_nxt = d_in;
    if (d_in.rem >= trial) begin
      stage_nxt.rem  = d_in.rem - trial;
      stage_nxt.root = (d_in.root >> 1) + BIT_VAL;
    end else begin
      stage_nxt.root = d_in.root >> 1;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= d_in.meta.valid;
  end

  // payload
  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  always_comb begin
    d_out            = stage_r;
    d_out.meta.valid = vld_r;
  end

endmodule

>>> rtl/core/atl_cordic_cell.sv
`timescale 1ns / 1ps
// atl_cordic_cell: one vectoring rotation of the arctangent chain, registered.
// Depends on atl_pkg (step angle table).
module atl_cordic_cell #(
  parameter int ITER = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  atl_pkg::atl_cordic_t d_in,
  output atl_pkg::atl_cordic_t d_out
);
  import atl_pkg::*;

  localparam logic signed [ATL_ACC_W-1:0] STEP_ANGLE = $signed(atl_atan_tab(ITER));

  logic signed [ATL_CW-1:0] dx;
  logic signed [ATL_CW-1:0] dy;
  atl_cordic_t              stage_nxt;
  atl_cordic_t              stage_r;
  logic                     vld_r;

  // rotate toward the x axis, sign of y picks the direction
  always_comb begin
    dx        = d_in.y >>> ITER;
    dy        = d_in.x >>> ITER;
    stage_nxt = d_in;
    if (!d_in.y[ATL_CW-1]) begin
      stage_nxt.x   = d_in.x + dx;
      stage_nxt.y   = d_in.y - dy;
      stage_nxt.acc = d_in.acc + STEP_ANGLE;
    end else begin
      stage_nxt.x   = d_in.x - dx;
      stage_nxt.y   = d_in.y + dy;
      stage_nxt.acc = d_in.acc - STEP_ANGLE;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= d_in.meta.valid;
  end

  // payload
  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  always_comb begin
    d_out            = stage_r;
    d_out.meta.valid = vld_r;
  end

endmodule

>>> rtl/core/atl_convert.sv
`timescale 1ns / 1ps
// atl_convert: four-stage conversion of a Q60 radian angle to signed output
// units (degree scale, rounding, divide by ten, sign). Depends on atl_pkg.
module atl_convert #(
  parameter int ANGLE_FRAC_BITS = atl_pkg::ATL_ANGLE_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  atl_pkg::atl_cordic_t              d_in,
  output logic                              res_valid,
  output logic signed [ANGLE_FRAC_BITS+8:0] res_angle
);
  import atl_pkg::*;

  localparam int OUT_W  = ANGLE_FRAC_BITS + 9;
  localparam int P_W    = ATL_Q_W + ATL_SCALE_W;
  localparam int RSH    = ATL_DIV_SHIFT - ANGLE_FRAC_BITS;
  localparam int W_W    = P_W - RSH + 1;
  localparam int PROD_W = W_W + ATL_RECIP_W;

  // stage 1: magnitude and the kept bits of the angle, zero for modes 2 and 3 or a zero vector
  logic [ATL_ACC_W-1:0] mag;
  logic [ATL_Q_W-1:0]   q_nxt;
  logic [ATL_Q_W-1:0]   q_r;
  logic                 neg1_r;
  logic                 dbl_r;
  logic                 vld1_r;

  always_comb begin
    mag = d_in.acc[ATL_ACC_W-1] ? $unsigned(-d_in.acc) : $unsigned(d_in.acc);
    if (d_in.zero || d_in.meta.mode[1]) q_nxt = '0;
    else q_nxt = mag[ATL_ANGLE_LSB +: ATL_Q_W];
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    neg1_r <= d_in.acc[ATL_ACC_W-1];
    dbl_r  <= (d_in.meta.mode == ATL_MODE_ROLL);
  end

  // stage 2: degree scale, doubling for roll, half-unit rounding offset
  logic [P_W-1:0] p_deg;
  logic [P_W-1:0] p_scaled;
  logic [W_W-1:0] w_nxt;
  logic [W_W-1:0] w_r;
  logic           neg2_r;
  logic           vld2_r;

  always_comb begin
    p_deg    = P_W'(q_r) * P_W'(ATL_DEG_SCALE);
    p_scaled = dbl_r ? (p_deg << 1) : p_deg;
    w_nxt    = W_W'(p_scaled >> RSH) + W_W'(ATL_ROUND_HALF);
  end

  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    neg2_r <= neg1_r;
  end

  // stage 3: reciprocal multiply for the divide by ten
  logic [PROD_W-1:0] prod_r;
  logic [W_W-1:0]    w3_r;
  logic              neg3_r;
  logic              vld3_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(w_r) * PROD_W'(ATL_RECIP_TEN);
    w3_r   <= w_r;
    neg3_r <= neg2_r;
  end

  // stage 4: quotient correction and output sign
  logic [W_W-1:0]          u0;
  logic [W_W-1:0]          ten_u0;
  logic [W_W-1:0]          rem;
  logic [W_W-1:0]          quo;
  logic signed [OUT_W-1:0] angle_nxt;
  logic signed [OUT_W-1:0] angle_r;
  logic                    vld4_r;

  always_comb begin
    u0     = W_W'(prod_r >> ATL_DIV_SHIFT);
    ten_u0 = (u0 << 3) + (u0 << 1);
    rem    = w3_r - ten_u0;
    quo    = (rem >= W_W'(ATL_RADIX)) ? u0 + W_W'(1) : u0;
    // the output is the negated angle
    angle_nxt = neg3_r ? $signed(OUT_W'(quo)) : -$signed(OUT_W'(quo));
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld1_r <= d_in.meta.valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  assign res_valid = vld4_r;
  assign res_angle = angle_r;

endmodule

>>> rtl/core/atl_checker.sv
`timescale 1ns / 1ps
// atl_checker: port-level checks of the tilt angle block, bound to the top.
// Depends on atl_pkg and accel_tilt_angle.
module atl_checker #(
  parameter int SAMPLE_BITS     = atl_pkg::ATL_SAMPLE_BITS,
  parameter int ANGLE_FRAC_BITS = atl_pkg::ATL_ANGLE_FRAC_BITS
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic signed [SAMPLE_BITS-1:0]     in_x_sample,
  input logic signed [SAMPLE_BITS-1:0]     in_y_sample,
  input logic signed [SAMPLE_BITS-1:0]     in_z_sample,
  input logic [1:0]                        in_mode,
  input logic                              out_valid,
  input logic signed [ANGLE_FRAC_BITS+8:0] out_angle_out
);
  import atl_pkg::*;

  logic acc_w;

  assign acc_w = start && !busy;

  // every accepted word gives a result strobe at fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(acc_w, ATL_LATENCY) |-> out_valid)
    else $error("accepted word gave no result strobe");

  // no result strobe without an accepted word
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc_w, ATL_LATENCY))
    else $error("result strobe without an accepted word");

  // yaw and unused modes give zero
  a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
    $past(acc_w && in_mode[1], ATL_LATENCY) |-> out_angle_out == '0)
    else $error("unused mode gave a nonzero angle");

  // level x axis gives zero vehicle roll
  a_level_roll: assert property (@(posedge clk) disable iff (!rst_n)
    $past(acc_w && (in_mode == ATL_MODE_ROLL) && (in_x_sample == '0), ATL_LATENCY)
    |-> out_angle_out == '0)
    else $error("zero x sample gave a nonzero roll");

  // zero y and z give zero vehicle pitch
  a_null_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    $past(acc_w && (in_mode == ATL_MODE_PITCH) && (in_y_sample == '0) &&
          (in_z_sample == '0), ATL_LATENCY)
    |-> out_angle_out == '0)
    else $error("zero vector gave a nonzero pitch");

endmodule

bind accel_tilt_angle atl_checker #(
  .SAMPLE_BITS     (SAMPLE_BITS),
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_atl_checker (.*);

>>> tb/accel_tilt_angle_tb.sv
`timescale 1ns / 1ps
// accel_tilt_angle_tb: self-checking regression for the accelerometer tilt block.
// Needs atl_pkg and accel_tilt_angle; it predicts each angle in 64-bit integer
// math and checks every strobed result in order against the oldest prediction.
module accel_tilt_angle_tb;
  import atl_pkg::*;

  localparam int SB = ATL_SAMPLE_BITS;
  localparam int FB = ATL_ANGLE_FRAC_BITS;
  localparam int OW = FB + 9;
  localparam int GUARD = 32 - SB;
  localparam int STEPS = 60;
  localparam int PRESCALE = 23;
  localparam int ANGLE_DROP = 28;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int RANDOM_WORDS = 1150;
  localparam int DRAIN_LIMIT = 20000;

  // scoreboard: angle predictor plus the queue of angles still owed
  class tilt_scoreboard;
    longint unsigned step_angle[STEPS];
    logic [OW-1:0]   owed_angles[$];
    int              mismatches;
    int              checked;
    int              per_mode[4];

    function new();
      step_angle[0] = inv_atan(2) + inv_atan(3);
      for (int i = 1; i < STEPS; i++) step_angle[i] = inv_atan(64'd1 << i);
      mismatches = 0;
      checked = 0;
      foreach (per_mode[m]) per_mode[m] = 0;
    endfunction

    // atan(1/n) in Q60 radians by the alternating series
    function longint unsigned inv_atan(longint unsigned n);
      longint unsigned p;
      longint unsigned sum;
      longint unsigned term;
      longint unsigned k;
      bit              neg;
      p = (64'd1 << 60) / n;
      sum = 0;
      k = 0;
      neg = 1'b0;
      while (p != 0) begin
        term = p / (2 * k + 1);
        if (neg) sum = sum - term;
        else sum = sum + term;
        neg = !neg;
        p = p / n / n;
        k++;
      end
      return sum;
    endfunction

    // floor square root, bit by bit
    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // vectoring rotation: atan2(yv, xv) in Q60 radians
    function longint rotate_atan2(longint yv, longint xv);
      longint x;
      longint y;
      longint t;
      longint dx;
      longint dy;
      longint acc;
      longint quarter;
      if (xv == 0 && yv == 0) return 0;
      quarter = 2 * step_angle[0];
      acc = 0;
      x = xv * (longint'(1) <<< PRESCALE);
      y = yv * (longint'(1) <<< PRESCALE);
      // left half plane: turn by a quarter first
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          acc = quarter;
        end else begin
          x = -y;
          y = t;
          acc = -quarter;
        end
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          acc = acc + longint'(step_angle[i]);
        end else begin
          x = x - dx;
          y = y + dy;
          acc = acc - longint'(step_angle[i]);
        end
      end
      return acc;
    endfunction

    // Q60 radians to output units, rounded half away from zero
    function longint deg_units(longint ang, longint unsigned mult);
      bit              neg;
      longint unsigned a;
      longint unsigned q;
      longint unsigned n;
      longint unsigned u;
      neg = ang < 0;
      a = neg ? -ang : ang;
      q = a >> ANGLE_DROP;
      n = (q * 573 * mult) << FB;
      u = (n + (64'd5 << 32)) / (64'd10 << 32);
      return neg ? -longint'(u) : longint'(u);
    endfunction

    function logic [OW-1:0] predict_angle(logic signed [SB-1:0] xs, logic signed [SB-1:0] ys,
                                          logic signed [SB-1:0] zs, logic [1:0] mode);
      longint          x;
      longint          y;
      longint          z;
      longint          yr;
      longint          zr;
      longint          res;
      longint unsigned sq;
      longint unsigned root;
      x = longint'(xs) * (longint'(1) <<< GUARD);
      y = longint'(ys) * (longint'(1) <<< GUARD);
      z = longint'(zs) * (longint'(1) <<< GUARD);
      case (mode)
        ATL_MODE_PITCH: begin
          res = -deg_units(rotate_atan2(y, z), 1);
        end
        ATL_MODE_ROLL: begin
          yr = longint'(ys);
          zr = longint'(zs);
          sq = yr * yr + zr * zr;
          root = int_sqrt(sq << (2 * GUARD));
          res = -deg_units(rotate_atan2(-x, longint'(root)), 2);
        end
        default: begin
          res = 0;
        end
      endcase
      return res[OW-1:0];
    endfunction

    function void note_word(logic signed [SB-1:0] xs, logic signed [SB-1:0] ys,
                            logic signed [SB-1:0] zs, logic [1:0] mode);
      owed_angles.push_back(predict_angle(xs, ys, zs, mode));
      per_mode[mode]++;
    endfunction

    function void check_angle(logic [OW-1:0] act);
      logic [OW-1:0] exp_angle;
      if (owed_angles.size() == 0) begin
        $display("%0t: unexpected angle %0d with nothing owed", $time, $signed(act));
        mismatches++;
      end else begin
        exp_angle = owed_angles.pop_front();
        checked++;
        if (act !== exp_angle) begin
          $display("%0t: angle mismatch: expected %0d, actual %0d", $time,
                   $signed(exp_angle), $signed(act));
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return owed_angles.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [SB-1:0] in_x_sample = '0;
  logic signed [SB-1:0] in_y_sample = '0;
  logic signed [SB-1:0] in_z_sample = '0;
  logic [1:0]           in_mode = ATL_MODE_PITCH;
  logic                 out_valid;
  logic signed [OW-1:0] out_angle_out;

  tilt_scoreboard sb = new();
  int             words_sent = 0;
  bit             allow_idle = 1'b1;

  accel_tilt_angle i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_x_sample  (in_x_sample),
    .in_y_sample  (in_y_sample),
    .in_z_sample  (in_z_sample),
    .in_mode      (in_mode),
    .out_valid    (out_valid),
    .out_angle_out(out_angle_out)
  );

  always #6 clk = ~clk;

  // note every accepted word
  always @(posedge clk) begin
    if (start === 1'b1 && busy === 1'b0) sb.note_word(in_x_sample, in_y_sample, in_z_sample,
                                                      in_mode);
  end

  // check every strobed angle
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_angle(out_angle_out);
  end

  // present one word and hold it until it is taken
  task automatic send_word(logic signed [SB-1:0] x, logic signed [SB-1:0] y,
                           logic signed [SB-1:0] z, logic [1:0] mode);
    in_x_sample <= x;
    in_y_sample <= y;
    in_z_sample <= z;
    in_mode <= mode;
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    words_sent++;
    // random idle cycles after the word
    while (allow_idle && $urandom_range(0, 99) < 17) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // sample value biased toward the extremes, zero and tiny magnitudes
  function automatic logic signed [SB-1:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return '0;
      1: return {1'b1, {(SB-1){1'b0}}};
      2: return {1'b0, {(SB-1){1'b1}}};
      3: return SB'($urandom_range(0, 16)) - SB'(8);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_mode();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return ATL_MODE_PITCH;
    else if (sel < 85) return ATL_MODE_ROLL;
    else if (sel < 95) return ATL_MODE_YAW;
    else return MODE_SPARE;
  endfunction

  task automatic run_directed();
    // pitch: zero vector, negative z axis, axis extremes
    send_word(SB'(0), SB'(0), SB'(0), ATL_MODE_PITCH);
    send_word(SB'(0), SB'(0), SB'(-32768), ATL_MODE_PITCH);
    send_word(SB'(0), SB'(0), SB'(-1), ATL_MODE_PITCH);
    send_word(SB'(0), SB'(32767), SB'(0), ATL_MODE_PITCH);
    send_word(SB'(0), SB'(-32768), SB'(0), ATL_MODE_PITCH);
    send_word(SB'(0), SB'(0), SB'(32767), ATL_MODE_PITCH);
    send_word(SB'(0), SB'(-32768), SB'(-32768), ATL_MODE_PITCH);
    send_word(SB'(0), SB'(32767), SB'(-32768), ATL_MODE_PITCH);
    send_word(SB'(-1), SB'(-1), SB'(-1), ATL_MODE_PITCH);
    // roll: zero vector, zero x, x extremes
    send_word(SB'(0), SB'(0), SB'(0), ATL_MODE_ROLL);
    send_word(SB'(0), SB'(5), SB'(7), ATL_MODE_ROLL);
    send_word(SB'(-32768), SB'(0), SB'(0), ATL_MODE_ROLL);
    send_word(SB'(32767), SB'(0), SB'(0), ATL_MODE_ROLL);
    send_word(SB'(-32768), SB'(32767), SB'(32767), ATL_MODE_ROLL);
    send_word(SB'(32767), SB'(-32768), SB'(-32768), ATL_MODE_ROLL);
    send_word(SB'(1), SB'(0), SB'(0), ATL_MODE_ROLL);
    send_word(SB'(-1), SB'(-1), SB'(-1), ATL_MODE_ROLL);
    // unused modes give zero
    send_word(SB'(123), SB'(456), SB'(789), ATL_MODE_YAW);
    send_word(SB'(-32768), SB'(-32768), SB'(-32768), ATL_MODE_YAW);
    send_word(SB'(32767), SB'(32767), SB'(32767), MODE_SPARE);
    send_word(SB'(-1), SB'(-1), SB'(-1), MODE_SPARE);
  endtask

  // run timeout
  initial begin
    #3000000;
    $display("accel_tilt_angle regression: fail");
    $finish;
  end

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    run_directed();
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // back-to-back stretch with no idling
      allow_idle = !(n >= 300 && n < 560);
      send_word(pick_sample(), pick_sample(), pick_sample(), pick_mode());
    end
    start <= 1'b0;
    waited = 0;
    while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() > 0) begin
      $display("%0t: %0d angles never arrived", $time, sb.pending());
      $display("accel_tilt_angle regression: fail");
      $finish;
    end else begin
      repeat (ATL_LATENCY + 10) @(posedge clk);
      $display("covered %0d words: pitch %0d, roll %0d, yaw %0d, spare mode %0d",
               words_sent, sb.per_mode[0], sb.per_mode[1], sb.per_mode[2], sb.per_mode[3]);
      $display("checked %0d angles, %0d mismatches, %0d still owed", sb.checked,
               sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
        $display("accel_tilt_angle regression: pass");
      end else begin
        $display("accel_tilt_angle regression: fail");
      end
      $finish;
    end
  end

endmodule
